@@ rtl/core/ffa_pkg.sv @@
// Shared types, codes and constants for the first-fit block allocator.
`timescale 1ns / 1ps
package ffa_pkg;

  localparam int          MAX_BLOCKS_DEF   = 64;
  localparam int          HEADER_BYTES_DEF = 40;
  localparam logic [31:0] MAX_REQUEST_RST  = 32'd100000000;
  localparam logic [31:0] HEAP_LIMIT_RST   = 32'd1048576;

  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_ZALLOC = 2'd1;
  localparam logic [1:0] CMD_FREE   = 2'd2;
  localparam logic [1:0] CMD_RESIZE = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE = 3'd1;
  localparam logic [2:0] ST_HEAP     = 3'd2;
  localparam logic [2:0] ST_TABLE    = 3'd3;
  localparam logic [2:0] ST_UNKNOWN  = 3'd4;

  localparam logic REG_MAX_REQUEST = 1'b0;
  localparam logic REG_HEAP_LIMIT  = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] size;
    logic [31:0] count;
    logic [31:0] address;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic [2:0]  status;
    logic [6:0]  free_blocks;
    logic [31:0] free_bytes;
    logic [6:0]  allocated_blocks;
    logic [31:0] allocated_bytes;
    logic [15:0] header_bytes;
  } out_item_t;

  // One table entry: free mark, header start offset, data size.
  typedef struct packed {
    logic        free;
    logic [31:0] start;
    logic [31:0] size;
  } entry_t;

endpackage

@@ rtl/core/ffa_table.sv @@
// Block table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module ffa_table
  import ffa_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic [IW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [MAX_BLOCKS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/core/ffa_ctrl.sv @@
// Request sequencer: table walks, read-modify-write, counters, result register.
`timescale 1ns / 1ps
module ffa_ctrl
  import ffa_pkg::*;
#(
  parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
  localparam int CW = $clog2(MAX_BLOCKS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  in_item_t      in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output out_item_t     out_data,
  input  logic [31:0]   max_request,
  input  logic [31:0]   heap_limit,
  output logic          wr_en,
  output logic [IW-1:0] wr_addr,
  output entry_t        wr_data,
  output logic [IW-1:0] rd_addr,
  input  entry_t        rd_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_FIND = 3'd3;
  localparam logic [2:0] S_FIT  = 3'd4;
  localparam logic [2:0] S_OLD  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  localparam logic [31:0] HDR32 = 32'(HEADER_BYTES);
  localparam logic [CW-1:0] MAXB = CW'(MAX_BLOCKS);
  localparam logic [CW-1:0] ONE  = CW'(1);

  logic [2:0]    state_r, state_nxt;
  in_item_t      req_in_r, req_in_nxt;
  logic [63:0]   req_r, req_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic          chk_vld_r, chk_vld_nxt;
  logic [IW-1:0] chk_idx_r, chk_idx_nxt;
  logic [IW-1:0] old_idx_r, old_idx_nxt;
  entry_t        old_ent_r, old_ent_nxt;
  logic [31:0]   res_r, res_nxt;
  logic [2:0]    st_r, st_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic [CW-1:0] free_cnt_r, free_cnt_nxt;
  logic [31:0]   free_bytes_r, free_bytes_nxt;
  logic [31:0]   alloc_bytes_r, alloc_bytes_nxt;
  logic [31:0]   brk_r, brk_nxt;
  logic [15:0]   hdr_r, hdr_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  logic        issue, exhausted, bad, addr_hit, fit_hit, has_old;
  logic [31:0] req32;
  logic [33:0] end_w;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign req32     = req_r[31:0];
  assign issue     = (scan_r < total_r);
  assign exhausted = !chk_vld_r && !issue;
  assign bad       = (req_r == 64'd0) || (req_r > {32'd0, max_request});
  assign addr_hit  = chk_vld_r &&
                     (({1'b0, rd_data.start} + {1'b0, HDR32}) == {1'b0, req_in_r.address});
  assign fit_hit   = chk_vld_r && rd_data.free && (rd_data.size >= req32);
  assign end_w     = {2'b00, brk_r} + {2'b00, req32} + {2'b00, HDR32};
  assign has_old   = (req_in_r.command == CMD_RESIZE) && (req_in_r.address != 32'd0);

  always_comb begin
    state_nxt       = state_r;
    req_in_nxt      = req_in_r;
    req_nxt         = req_r;
    scan_nxt        = scan_r;
    chk_vld_nxt     = 1'b0;
    chk_idx_nxt     = chk_idx_r;
    old_idx_nxt     = old_idx_r;
    old_ent_nxt     = old_ent_r;
    res_nxt         = res_r;
    st_nxt          = st_r;
    total_nxt       = total_r;
    free_cnt_nxt    = free_cnt_r;
    free_bytes_nxt  = free_bytes_r;
    alloc_bytes_nxt = alloc_bytes_r;
    brk_nxt         = brk_r;
    hdr_nxt         = hdr_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_data_nxt    = out_data_r;
    wr_en           = 1'b0;
    wr_addr         = chk_idx_r;
    wr_data         = rd_data;
    rd_addr         = scan_r[IW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_in_nxt = in_data;
          res_nxt    = 32'd0;
          st_nxt     = ST_OK;
          state_nxt  = S_MUL;
        end
      end
      S_MUL: begin
        if (req_in_r.command == CMD_ZALLOC) begin
          req_nxt = 64'(req_in_r.size) * 64'(req_in_r.count);
        end else begin
          req_nxt = {32'd0, req_in_r.size};
        end
        state_nxt = S_CHK;
      end
      S_CHK: begin
        scan_nxt = '0;
        if (req_in_r.command == CMD_FREE) begin
          state_nxt = (req_in_r.address == 32'd0) ? S_DONE : S_FIND;
        end else if (bad) begin
          st_nxt    = ST_BAD_SIZE;
          state_nxt = S_DONE;
        end else begin
          state_nxt = has_old ? S_FIND : S_FIT;
        end
      end
      S_FIND: begin
        chk_vld_nxt = issue;
        chk_idx_nxt = scan_r[IW-1:0];
        scan_nxt    = scan_r + CW'(issue);
        if (addr_hit) begin
          old_idx_nxt = chk_idx_r;
          old_ent_nxt = rd_data;
          chk_vld_nxt = 1'b0;
          if (req_in_r.command == CMD_FREE) begin
            if (!rd_data.free) begin
              wr_en          = 1'b1;
              wr_data.free   = 1'b1;
              free_cnt_nxt   = free_cnt_r + ONE;
              free_bytes_nxt = free_bytes_r + rd_data.size;
            end
            state_nxt = S_DONE;
          end else if (rd_data.size >= req32) begin
            res_nxt   = req_in_r.address;
            state_nxt = S_DONE;
          end else begin
            scan_nxt  = '0;
            state_nxt = S_FIT;
          end
        end else if (exhausted) begin
          st_nxt    = ST_UNKNOWN;
          state_nxt = S_DONE;
        end
      end
      S_FIT: begin
        chk_vld_nxt = issue;
        chk_idx_nxt = scan_r[IW-1:0];
        scan_nxt    = scan_r + CW'(issue);
        if (fit_hit) begin
          wr_en          = 1'b1;
          wr_data.free   = 1'b0;
          free_cnt_nxt   = free_cnt_r - ONE;
          free_bytes_nxt = free_bytes_r - rd_data.size;
          res_nxt        = rd_data.start + HDR32;
          chk_vld_nxt    = 1'b0;
          state_nxt      = has_old ? S_OLD : S_DONE;
        end else if (exhausted) begin
          if (end_w > {2'b00, heap_limit}) begin
            st_nxt    = ST_HEAP;
            state_nxt = S_DONE;
          end else if (total_r >= MAXB) begin
            st_nxt    = ST_TABLE;
            state_nxt = S_DONE;
          end else begin
            wr_en           = 1'b1;
            wr_addr         = total_r[IW-1:0];
            wr_data.free    = 1'b0;
            wr_data.start   = brk_r;
            wr_data.size    = req32;
            total_nxt       = total_r + ONE;
            alloc_bytes_nxt = alloc_bytes_r + req32;
            brk_nxt         = end_w[31:0];
            hdr_nxt         = hdr_r + HDR32[15:0];
            res_nxt         = brk_r + HDR32;
            state_nxt       = has_old ? S_OLD : S_DONE;
          end
        end
      end
      S_OLD: begin
        // Release the block the resize moved away from.
        if (!old_ent_r.free) begin
          wr_en          = 1'b1;
          wr_addr        = old_idx_r;
          wr_data        = old_ent_r;
          wr_data.free   = 1'b1;
          free_cnt_nxt   = free_cnt_r + ONE;
          free_bytes_nxt = free_bytes_r + old_ent_r.size;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.result_address   = res_r;
          out_data_nxt.status           = st_r;
          out_data_nxt.free_blocks      = 7'(free_cnt_r);
          out_data_nxt.free_bytes       = free_bytes_r;
          out_data_nxt.allocated_blocks = 7'(total_r);
          out_data_nxt.allocated_bytes  = alloc_bytes_r;
          out_data_nxt.header_bytes     = hdr_r;
          state_nxt                     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      chk_vld_r     <= 1'b0;
      total_r       <= '0;
      free_cnt_r    <= '0;
      free_bytes_r  <= '0;
      alloc_bytes_r <= '0;
      brk_r         <= '0;
      hdr_r         <= '0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      chk_vld_r     <= chk_vld_nxt;
      total_r       <= total_nxt;
      free_cnt_r    <= free_cnt_nxt;
      free_bytes_r  <= free_bytes_nxt;
      alloc_bytes_r <= alloc_bytes_nxt;
      brk_r         <= brk_nxt;
      hdr_r         <= hdr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_in_r   <= req_in_nxt;
    req_r      <= req_nxt;
    scan_r     <= scan_nxt;
    chk_idx_r  <= chk_idx_nxt;
    old_idx_r  <= old_idx_nxt;
    old_ent_r  <= old_ent_nxt;
    res_r      <= res_nxt;
    st_r       <= st_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ rtl/core/first_fit_block_allocator_top.sv @@
// Top level of the first-fit block allocator: config registers, sequencer, table.
// Free and allocate walk the block table at most once per request; a resize that moves
//   walks it twice, first to find the old block and then to place the new one.
// Throughput: one request at a time; each table walk reads one entry per cycle through the
//   single read port of the table memory.
// Reset (rst_n, synchronous, active low) empties the table, clears the counters and the
//   heap break, and loads max_request and heap_limit with their defaults.
`timescale 1ns / 1ps
module first_fit_block_allocator_top
  import ffa_pkg::*;
#(
  parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  logic [31:0]   max_request_r, max_request_nxt;
  logic [31:0]   heap_limit_r, heap_limit_nxt;
  logic          wr_en;
  logic [IW-1:0] wr_addr, rd_addr;
  entry_t        wr_data, rd_data;

  // Config writes are registered; the user must send them only while the block is idle, which the block does not check.
  assign cfg_ready = 1'b1;

  always_comb begin
    max_request_nxt = max_request_r;
    heap_limit_nxt  = heap_limit_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_MAX_REQUEST: max_request_nxt = cfg_data;
        REG_HEAP_LIMIT:  heap_limit_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_request_r <= MAX_REQUEST_RST;
      heap_limit_r  <= HEAP_LIMIT_RST;
    end else begin
      max_request_r <= max_request_nxt;
      heap_limit_r  <= heap_limit_nxt;
    end
  end

  // Sequencer: walks the table, applies each request, holds the result until taken.
  ffa_ctrl #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .max_request(max_request_r),
    .heap_limit (heap_limit_r),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  // Block table: entries beyond the block count are never used.
  ffa_table #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

endmodule

@@ rtl/core/ffa_checker.sv @@
// Port-level checker for the allocator, bound to the top level.
`timescale 1ns / 1ps
module ffa_checker
  import ffa_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input out_item_t   out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_free_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.free_blocks <= out_data.allocated_blocks)
    else $error("more free blocks than blocks");

  a_fail_null: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.result_address == 32'd0)
    else $error("failed request returned an address");

  a_free_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.free_bytes <= out_data.allocated_bytes)
    else $error("free bytes exceed allocated bytes");

endmodule

bind first_fit_block_allocator_top ffa_checker u_ffa_checker (.*);

@@ dv/tb_first_fit_block_allocator_top.sv @@
// Self-checking testbench for the first-fit block allocator: directed table, table fill, then random.
`timescale 1ns / 1ps
module tb_first_fit_block_allocator_top;
  import ffa_pkg::*;

  localparam int NBLK = MAX_BLOCKS_DEF;
  localparam int HDR  = HEADER_BYTES_DEF;
  localparam int CYCLE_LIMIT = 1500000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_index;
  logic [31:0] cfg_data;

  first_fit_block_allocator_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shadow copy of the allocator state, kept in step with accepted requests.
  logic [31:0] shd_size  [NBLK];
  logic [31:0] shd_start [NBLK];
  logic        shd_free  [NBLK];
  int unsigned shd_total;
  logic [31:0] shd_break;
  logic [6:0]  shd_free_cnt;
  logic [31:0] shd_free_bytes;
  logic [31:0] shd_alloc_bytes;
  logic [31:0] shd_max_req;
  logic [31:0] shd_heap_lim;

  out_item_t   pending_results[$];
  int          errors;
  int          n_results;
  int          n_requests;
  longint      cycles;
  bit          hold_sink;   // long receiver hold-off while set
  bit          calm;        // no random idling while set

  function automatic int find_entry(logic [31:0] addr);
    for (int i = 0; i < shd_total; i++)
      if ({32'd0, shd_start[i]} + HDR == {32'd0, addr}) return i;
    return -1;
  endfunction

  function automatic void mark_entry_free(int i);
    if (!shd_free[i]) begin
      shd_free[i] = 1'b1;
      shd_free_cnt++;
      shd_free_bytes += shd_size[i];
    end
  endfunction

  function automatic logic [31:0] place_block(logic [31:0] req, output logic [2:0] st);
    logic [63:0] end_off;
    for (int i = 0; i < shd_total; i++) begin
      if (shd_free[i] && shd_size[i] >= req) begin
        shd_free[i] = 1'b0;
        shd_free_cnt--;
        shd_free_bytes -= shd_size[i];
        st = ST_OK;
        return shd_start[i] + HDR;
      end
    end
    end_off = {32'd0, shd_break} + req + HDR;
    if (end_off > {32'd0, shd_heap_lim}) begin
      st = ST_HEAP;
      return 0;
    end
    if (shd_total >= NBLK) begin
      st = ST_TABLE;
      return 0;
    end
    shd_size[shd_total]  = req;
    shd_start[shd_total] = shd_break;
    shd_free[shd_total]  = 1'b0;
    shd_total++;
    shd_alloc_bytes += req;
    shd_break = end_off[31:0];
    st = ST_OK;
    return end_off[31:0] - req;
  endfunction

  function automatic bit size_fits(logic [63:0] req);
    return req != 0 && req <= {32'd0, shd_max_req};
  endfunction

  // Advance the shadow state by one request and return the result it yields.
  function automatic out_item_t allocator_result(in_item_t rq);
    out_item_t   r;
    logic [2:0]  st;
    logic [31:0] res;
    logic [63:0] prod;
    int          idx;
    st = ST_OK;
    res = 0;
    case (rq.command)
      CMD_ALLOC: begin
        if (size_fits({32'd0, rq.size})) res = place_block(rq.size, st);
        else st = ST_BAD_SIZE;
      end
      CMD_ZALLOC: begin
        prod = {32'd0, rq.size} * {32'd0, rq.count};
        if (rq.size != 0 && rq.count != 0 && size_fits(prod)) res = place_block(prod[31:0], st);
        else st = ST_BAD_SIZE;
      end
      CMD_FREE: begin
        if (rq.address != 0) begin
          idx = find_entry(rq.address);
          if (idx < 0) st = ST_UNKNOWN;
          else mark_entry_free(idx);
        end
      end
      default: begin
        if (!size_fits({32'd0, rq.size})) begin
          st = ST_BAD_SIZE;
        end else if (rq.address == 0) begin
          res = place_block(rq.size, st);
        end else begin
          idx = find_entry(rq.address);
          if (idx < 0) begin
            st = ST_UNKNOWN;
          end else if (shd_size[idx] >= rq.size) begin
            res = rq.address;
          end else begin
            res = place_block(rq.size, st);
            if (st == ST_OK) mark_entry_free(idx);
          end
        end
      end
    endcase
    r.result_address   = res;
    r.status           = st;
    r.free_blocks      = shd_free_cnt;
    r.free_bytes       = shd_free_bytes;
    r.allocated_blocks = shd_total[6:0];
    r.allocated_bytes  = shd_alloc_bytes;
    r.header_bytes     = 16'(shd_total * HDR);
    return r;
  endfunction

  function automatic void clear_shadow();
    shd_total = 0;
    shd_break = 0;
    shd_free_cnt = 0;
    shd_free_bytes = 0;
    shd_alloc_bytes = 0;
    shd_max_req = MAX_REQUEST_RST;
    shd_heap_lim = HEAP_LIMIT_RST;
  endfunction

  // Directed table: rows with typed-in results are checked against that value too.
  typedef struct {
    in_item_t  rq;
    bit        typed;
    out_item_t want;
  } dir_row_t;
  dir_row_t dir_rows[$];

  function automatic out_item_t mk_out(logic [31:0] a, logic [2:0] s, logic [6:0] fb,
                                       logic [31:0] fby, logic [6:0] ab, logic [31:0] aby);
    out_item_t o;
    o = '{a, s, fb, fby, ab, aby, 16'(ab * HDR)};
    return o;
  endfunction

  function automatic void add_row(logic [1:0] c, logic [31:0] s, logic [31:0] n,
                                  logic [31:0] a, bit typed, out_item_t w);
    dir_row_t d;
    d.rq = '{c, s, n, a};
    d.typed = typed;
    d.want = w;
    dir_rows.push_back(d);
  endfunction

  // Typed-in results that disagree with the shadow are a table error, reported too.
  task automatic send_request(in_item_t rq, bit typed, out_item_t want);
    out_item_t e;
    in_valid <= 1'b1;
    in_data  <= rq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    e = allocator_result(rq);
    if (typed && e !== want) begin
      $display("%0t directed row: expected %h actual %h", $time, want, e);
      errors++;
    end
    pending_results.push_back(e);
    n_requests++;
    // Drop valid for a random gap, unless calm asks for none.
    if (!calm && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * NBLK + 20) @(posedge clk);
  endtask

  // Drop valid after the write and wait before returning, so writes never share a time step.
  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_MAX_REQUEST) shd_max_req = val;
    else shd_heap_lim = val;
    @(posedge clk);
  endtask

  // Pick a live data address most of the time so frees and resizes hit real blocks.
  function automatic logic [31:0] pick_addr();
    int k;
    k = $urandom_range(0, 99);
    if (shd_total != 0 && k < 75) return shd_start[$urandom_range(0, shd_total - 1)] + HDR;
    if (k < 85) return 0;
    if (k < 92) return $urandom;
    return 32'hFFFF_FFFF - $urandom_range(0, 1);
  endfunction

  function automatic in_item_t rand_request();
    in_item_t rq;
    int k;
    rq.command = 2'($urandom_range(0, 3));
    k = $urandom_range(0, 99);
    if (k < 80) rq.size = $urandom_range(1, 3000);
    else if (k < 88) rq.size = $urandom;
    else if (k < 94) rq.size = 0;
    else rq.size = shd_max_req + $urandom_range(0, 1);
    k = $urandom_range(0, 99);
    if (k < 80) rq.count = $urandom_range(1, 16);
    else if (k < 90) rq.count = $urandom;
    else rq.count = 0;
    rq.address = pick_addr();
    return rq;
  endfunction

  // Receiver: random stalls, a long hold-off when asked, and the result check.
  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result %h", $time, out_data);
          errors++;
        end else begin
          e = pending_results.pop_front();
          if (out_data.result_address !== e.result_address)
            $display("%0t result_address expected %h actual %h", $time, e.result_address,
                     out_data.result_address);
          if (out_data.status !== e.status)
            $display("%0t status expected %0d actual %0d", $time, e.status, out_data.status);
          if (out_data.free_blocks !== e.free_blocks)
            $display("%0t free_blocks expected %0d actual %0d", $time, e.free_blocks,
                     out_data.free_blocks);
          if (out_data.free_bytes !== e.free_bytes)
            $display("%0t free_bytes expected %0d actual %0d", $time, e.free_bytes,
                     out_data.free_bytes);
          if (out_data.allocated_blocks !== e.allocated_blocks)
            $display("%0t allocated_blocks expected %0d actual %0d", $time,
                     e.allocated_blocks, out_data.allocated_blocks);
          if (out_data.allocated_bytes !== e.allocated_bytes)
            $display("%0t allocated_bytes expected %0d actual %0d", $time,
                     e.allocated_bytes, out_data.allocated_bytes);
          if (out_data.header_bytes !== e.header_bytes)
            $display("%0t header_bytes expected %0d actual %0d", $time, e.header_bytes,
                     out_data.header_bytes);
          if (out_data !== e) errors++;
        end
      end
      out_ready <= !hold_sink && (calm || $urandom_range(0, 99) >= 38);
    end
  end

  // Watchdog: count cycles and bail out past the limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    out_item_t nil;
    nil = '0;
    errors = 0;
    n_results = 0;
    n_requests = 0;
    cycles = 0;
    hold_sink = 1'b0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_MAX_REQUEST;
    cfg_data = '0;
    clear_shadow();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, default registers. Typed rows: null free, bad sizes, appends, frees, heap full.
    add_row(CMD_FREE,   0, 0, 0, 1, mk_out(0, ST_OK, 0, 0, 0, 0));
    add_row(CMD_ALLOC,  0, 0, 0, 1, mk_out(0, ST_BAD_SIZE, 0, 0, 0, 0));
    add_row(CMD_ALLOC,  32'hFFFF_FFFF, 0, 0, 1, mk_out(0, ST_BAD_SIZE, 0, 0, 0, 0));
    add_row(CMD_ALLOC,  MAX_REQUEST_RST + 1, 0, 0, 1, mk_out(0, ST_BAD_SIZE, 0, 0, 0, 0));
    add_row(CMD_ZALLOC, 0, 5, 0, 1, mk_out(0, ST_BAD_SIZE, 0, 0, 0, 0));
    add_row(CMD_ZALLOC, 7, 0, 0, 1, mk_out(0, ST_BAD_SIZE, 0, 0, 0, 0));
    add_row(CMD_ZALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1,
            mk_out(0, ST_BAD_SIZE, 0, 0, 0, 0));
    add_row(CMD_ALLOC,  100, 0, 0, 1, mk_out(40, ST_OK, 0, 0, 1, 100));
    add_row(CMD_ZALLOC, 4, 25, 32'hFFFF_FFFF, 1, mk_out(180, ST_OK, 0, 0, 2, 200));
    add_row(CMD_FREE,   0, 0, 41, 1, mk_out(0, ST_UNKNOWN, 0, 0, 2, 200));
    add_row(CMD_ALLOC,  HEAP_LIMIT_RST, 0, 0, 1, mk_out(0, ST_HEAP, 0, 0, 2, 200));
    add_row(CMD_FREE,   0, 0, 40, 1, mk_out(0, ST_OK, 1, 100, 2, 200));
    add_row(CMD_FREE,   0, 0, 40, 1, mk_out(0, ST_OK, 1, 100, 2, 200));
    add_row(CMD_ALLOC,  50, 0, 0, 0, nil);      // reuses the freed block, no split
    add_row(CMD_RESIZE, 80, 0, 40, 0, nil);     // large enough: same address
    add_row(CMD_RESIZE, 300, 0, 180, 0, nil);   // moves, old block freed
    add_row(CMD_RESIZE, 10, 0, 0, 0, nil);      // null resize allocates
    add_row(CMD_RESIZE, 10, 0, 12345, 0, nil);  // unknown address
    add_row(CMD_RESIZE, 0, 0, 40, 0, nil);
    add_row(CMD_RESIZE, HEAP_LIMIT_RST, 0, 40, 0, nil); // failing move keeps the old block
    add_row(CMD_FREE,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, nil);
    foreach (dir_rows[i]) send_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);
    wait_drained();

    // Fill the table with tiny blocks under a stalled receiver until it is full.
    hold_sink = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_sink = 1'b0;
      end
      for (int i = 0; i < 70; i++) send_request('{CMD_ALLOC, 32'd1, 32'd0, 32'd0}, 0, nil);
    join
    wait_drained();

    // Settings: extremes and ordinary values, random traffic in each, drained between.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_MAX_REQUEST, 32'hFFFF_FFFF);
          write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
        end
        1: begin
          write_reg(REG_MAX_REQUEST, 32'd1);
          write_reg(REG_HEAP_LIMIT, 32'd0);
        end
        2: begin
          write_reg(REG_MAX_REQUEST, 32'd2000);
          write_reg(REG_HEAP_LIMIT, 32'd20000);
        end
        3: begin
          write_reg(REG_MAX_REQUEST, 32'd3000);
          write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
        end
        default: begin
          write_reg(REG_MAX_REQUEST, MAX_REQUEST_RST);
          write_reg(REG_HEAP_LIMIT, HEAP_LIMIT_RST);
        end
      endcase
      calm = (ph == 2);
      for (int i = 0; i < 80; i++) send_request(rand_request(), 0, nil);
      calm = 1'b0;
      wait_drained();  // sender pauses until every result is back
    end

    $display("covered %0d requests and %0d results over five register settings,",
             n_requests, n_results);
    $display("including a full table, heap exhaustion and a long receiver stall");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
